/* sv/packet_framer_ones_complement_sum_core_assert.svh */
// Assertion helpers used by the framer core RTL.
`ifndef PACKET_FRAMER_ONES_COMPLEMENT_SUM_CORE_ASSERT_SVH
`define PACKET_FRAMER_ONES_COMPLEMENT_SUM_CORE_ASSERT_SVH

// Same-cycle implication.
`define PFOCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfocs assertion failed");

// Next-cycle implication.
`define PFOCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfocs assertion failed");

`endif

/* sv/pfocs_pkg.sv */
`timescale 1ns / 1ps

package pfocs_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 12;
	localparam int TYPE_W  = 6;
	localparam int SUM_W   = 16;
	localparam int PORT_W  = 16;
	localparam int SID_W   = 14;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [BYTE_W-1:0] HDR_VERSION    = 8'd12;
	localparam logic [PORT_W-1:0] CTRL_DST_PORT  = 16'h1874;
	localparam logic [PORT_W-1:0] MSG_DST_PORT   = 16'h0ECE;
	localparam logic [3:0]        CTRL_TYPE      = 4'd0;
	localparam logic [3:0]        MSG_TYPE       = 4'd4;
	localparam logic [LEN_W-1:0]  MSG_SUBHDR_LEN = 12'd4;

	localparam logic [PORT_W-1:0] SOURCE_PORT_RST = 16'd1183;
	localparam logic [SID_W-1:0]  SESSION_ID_RST  = 14'd786;

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_PAYLOAD = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_CONTROL = 1'b0,
		KIND_MESSAGE = 1'b1
	} kind_t;

	typedef enum logic [0:0] {
		REG_SOURCE_PORT = 1'b0,
		REG_SESSION_ID  = 1'b1
	} reg_idx_t;

	// byte position within a packet
	typedef enum logic [3:0] {
		SLOT_VER    = 4'd0,
		SLOT_SRC_LO = 4'd1,
		SLOT_SRC_HI = 4'd2,
		SLOT_DST_LO = 4'd3,
		SLOT_DST_HI = 4'd4,
		SLOT_LT_LO  = 4'd5,
		SLOT_LT_HI  = 4'd6,
		SLOT_PAD    = 4'd7,
		SLOT_SUB0   = 4'd8,
		SLOT_SUB1   = 4'd9,
		SLOT_SUB2   = 4'd10,
		SLOT_SUB3   = 4'd11,
		SLOT_CK_LO  = 4'd12,
		SLOT_CK_HI  = 4'd13,
		SLOT_DATA   = 4'd14
	} slot_t;

	typedef struct packed {
		logic [PORT_W-1:0] source_port;
		logic [SID_W-1:0]  session_id;
	} cfg_t;

endpackage

/* sv/pfocs_if.sv */
`timescale 1ns / 1ps

interface pfocs_item_if import pfocs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic              packet_kind;
	logic [TYPE_W-1:0] message_type;
	logic [LEN_W-1:0]  payload_length;
	logic [BYTE_W-1:0] data_byte;

	modport source (
		output valid, command, packet_kind, message_type, payload_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, command, packet_kind, message_type, payload_length, data_byte,
		output ready
	);
endinterface

interface pfocs_result_if import pfocs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (
		output valid, out_byte, last,
		input  ready
	);
	modport sink (
		input  valid, out_byte, last,
		output ready
	);
endinterface

/* sv/pfocs_regs.sv */
`timescale 1ns / 1ps

module pfocs_regs import pfocs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	logic [PORT_W-1:0] source_port_q;
	logic [SID_W-1:0]  session_id_q;
	reg_idx_t          idx;
	logic              wr_en;

	assign idx   = reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_port_q <= SOURCE_PORT_RST;
			session_id_q  <= SESSION_ID_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SOURCE_PORT: source_port_q <= pwdata[PORT_W-1:0];
				REG_SESSION_ID:  session_id_q  <= pwdata[SID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SOURCE_PORT: prdata = {{(PDATA_W-PORT_W){1'b0}}, source_port_q};
			REG_SESSION_ID:  prdata = {{(PDATA_W-SID_W){1'b0}}, session_id_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.source_port = source_port_q;
	assign cfg.session_id  = session_id_q;

endmodule

/* sv/packet_framer_ones_complement_sum_core.sv */
// Packet framer with a running ones'-complement checksum. One byte leaves per cycle on the
// result channel while it is ready. A payload byte in an open packet yields one byte, or
// three when it is the last one and the two checksum bytes follow; a start item yields one
// byte per slot, 7 to 12 bytes, 9 to 13 with the empty-payload checksum. A payload byte
// with no packet open is consumed and produces nothing. The item register holds one item
// while its bytes go out, and the next item is taken in the cycle its last byte enters
// the output register, so the output beat rate is the limit. The 16-bit end-around add runs
// once per byte pair in the same cycle. Configuration: source_port at byte address 0,
// session_id at byte address 4.
`timescale 1ns / 1ps
`include "packet_framer_ones_complement_sum_core_assert.svh"

module packet_framer_ones_complement_sum_core import pfocs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pfocs_item_if.sink         item,
	pfocs_result_if.source     result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	function automatic logic [SUM_W-1:0] ocs_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
	endfunction

	cfg_t cfg;

	pfocs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// item register
	logic              valid_s1;
	logic              kind_s1;
	logic [TYPE_W-1:0] mtype_s1;
	logic [LEN_W-1:0]  plen_s1;
	logic [BYTE_W-1:0] dbyte_s1;
	slot_t             slot_q;

	// packet state
	logic              open_q;
	logic [LEN_W-1:0]  bytes_left_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BYTE_W-1:0] held_q;
	logic              pending_q;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              slot_free;
	logic              drop;
	logic              fire;
	logic              done;
	logic              accept;
	logic              is_msg;
	logic              plen_zero;
	logic [LEN_W-1:0]  carried;
	logic [SUM_W-1:0]  fin_sum;
	logic [SUM_W-1:0]  ck;
	logic [SUM_W-1:0]  pair_sum;
	logic [BYTE_W-1:0] byte_c;
	logic              last_c;
	logic              has_next;
	slot_t             next_slot;

	assign slot_free = !out_valid_q || result.ready;
	assign drop      = valid_s1 && (slot_q == SLOT_DATA) && !open_q;
	assign fire      = valid_s1 && !drop && slot_free;
	assign done      = drop || (fire && !has_next);
	assign item.ready = !valid_s1 || done;
	assign accept    = item.valid && item.ready;

	assign is_msg    = (kind_s1 == KIND_MESSAGE);
	assign plen_zero = (plen_s1 == '0);
	assign carried   = is_msg ? plen_s1 + MSG_SUBHDR_LEN : plen_s1;
	assign fin_sum   = pending_q ? ocs_add(sum_q, {held_q, {BYTE_W{1'b0}}}) : sum_q;
	assign ck        = ~fin_sum;
	assign pair_sum  = ocs_add(sum_q, {held_q, byte_c});

	always_comb begin
		byte_c    = '0;
		last_c    = 1'b0;
		has_next  = 1'b1;
		next_slot = SLOT_VER;
		case (slot_q)
			SLOT_VER: begin
				byte_c    = HDR_VERSION;
				next_slot = SLOT_SRC_LO;
			end
			SLOT_SRC_LO: begin
				byte_c    = cfg.source_port[7:0];
				next_slot = SLOT_SRC_HI;
			end
			SLOT_SRC_HI: begin
				byte_c    = cfg.source_port[15:8];
				next_slot = SLOT_DST_LO;
			end
			SLOT_DST_LO: begin
				byte_c    = is_msg ? MSG_DST_PORT[7:0] : CTRL_DST_PORT[7:0];
				next_slot = SLOT_DST_HI;
			end
			SLOT_DST_HI: begin
				byte_c    = is_msg ? MSG_DST_PORT[15:8] : CTRL_DST_PORT[15:8];
				next_slot = SLOT_LT_LO;
			end
			SLOT_LT_LO: begin
				byte_c    = carried[7:0];
				next_slot = SLOT_LT_HI;
			end
			SLOT_LT_HI: begin
				byte_c = {(is_msg ? MSG_TYPE : CTRL_TYPE), carried[11:8]};
				if (carried[0]) begin
					next_slot = SLOT_PAD;
				end else if (is_msg) begin
					next_slot = SLOT_SUB0;
				end else if (plen_zero) begin
					next_slot = SLOT_CK_LO;
				end else begin
					has_next = 1'b0;
				end
			end
			SLOT_PAD: begin
				byte_c = '0;
				if (is_msg) begin
					next_slot = SLOT_SUB0;
				end else if (plen_zero) begin
					next_slot = SLOT_CK_LO;
				end else begin
					has_next = 1'b0;
				end
			end
			SLOT_SUB0: begin
				byte_c    = cfg.session_id[7:0];
				next_slot = SLOT_SUB1;
			end
			SLOT_SUB1: begin
				byte_c    = {mtype_s1[5:4], cfg.session_id[13:8]};
				next_slot = SLOT_SUB2;
			end
			SLOT_SUB2: begin
				byte_c    = {mtype_s1[3:0], plen_s1[11:8]};
				next_slot = SLOT_SUB3;
			end
			SLOT_SUB3: begin
				byte_c = plen_s1[7:0];
				if (plen_zero) begin
					next_slot = SLOT_CK_LO;
				end else begin
					has_next = 1'b0;
				end
			end
			SLOT_CK_LO: begin
				byte_c    = ck[7:0];
				next_slot = SLOT_CK_HI;
			end
			SLOT_CK_HI: begin
				byte_c   = ~sum_q[15:8];
				last_c   = 1'b1;
				has_next = 1'b0;
			end
			SLOT_DATA: begin
				byte_c = dbyte_s1;
				if (bytes_left_q == {{(LEN_W-1){1'b0}}, 1'b1}) begin
					next_slot = SLOT_CK_LO;
				end else begin
					has_next = 1'b0;
				end
			end
			default: begin
				has_next = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			slot_q   <= SLOT_VER;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			slot_q   <= (item.command == CMD_PAYLOAD) ? SLOT_DATA : SLOT_VER;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			slot_q <= next_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= item.packet_kind;
			mtype_s1 <= item.message_type;
			plen_s1  <= item.payload_length;
			dbyte_s1 <= item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			bytes_left_q <= '0;
			sum_q        <= '0;
			held_q       <= '0;
			pending_q    <= 1'b0;
		end else if (fire) begin
			case (slot_q)
				SLOT_VER: begin
					open_q       <= 1'b1;
					bytes_left_q <= plen_s1;
					sum_q        <= '0;
					held_q       <= byte_c;
					pending_q    <= 1'b1;
				end
				SLOT_CK_LO: begin
					sum_q     <= fin_sum;
					held_q    <= '0;
					pending_q <= 1'b0;
				end
				SLOT_CK_HI: begin
					open_q       <= 1'b0;
					bytes_left_q <= '0;
					sum_q        <= '0;
					held_q       <= '0;
					pending_q    <= 1'b0;
				end
				default: begin
					if (slot_q == SLOT_DATA) begin
						bytes_left_q <= bytes_left_q - {{(LEN_W-1){1'b0}}, 1'b1};
					end
					if (pending_q) begin
						sum_q     <= pair_sum;
						held_q    <= '0;
						pending_q <= 1'b0;
					end else begin
						held_q    <= byte_c;
						pending_q <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= byte_c;
			out_last_q <= last_c;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.last     = out_last_q;

	`PFOCS_ASSERT_IMP(a_data_has_count, clk, arst_n, valid_s1 && slot_q == SLOT_DATA && open_q, bytes_left_q != '0)
	`PFOCS_ASSERT_IMP(a_ck_hi_folded, clk, arst_n, valid_s1 && slot_q == SLOT_CK_HI, !pending_q)
	`PFOCS_ASSERT_NXT(a_close_after_ck, clk, arst_n, fire && slot_q == SLOT_CK_HI, !open_q && sum_q == '0 && out_valid_q && out_last_q)
	`PFOCS_ASSERT_IMP(a_last_closed, clk, arst_n, out_valid_q && out_last_q, !open_q)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import pfocs_pkg::*;

	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} beat_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pfocs_item_if   item_ch ();
	pfocs_result_if result_ch ();

	packet_framer_ones_complement_sum_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// framer shadow: config and checksum state
	logic [PORT_W-1:0] src_port_q;
	logic [SID_W-1:0]  sess_id_q;
	bit                pk_open;
	logic [LEN_W-1:0]  pk_left;
	logic [SUM_W-1:0]  csum;
	logic [BYTE_W-1:0] held;
	bit                odd_pend;
	beat_t             exp_beats[$];

	int fails;
	int n_items;
	int n_strays;
	int n_beats;
	int n_packets;
	int n_settings;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void fold_word(input logic [SUM_W-1:0] w);
		logic [SUM_W:0] s;
		s = {1'b0, csum} + {1'b0, w};
		csum = s[SUM_W-1:0] + {15'd0, s[SUM_W]};
	endfunction

	function automatic void emit_byte(input logic [BYTE_W-1:0] b);
		exp_beats.push_back('{out_byte: b, last: 1'b0});
		if (odd_pend) begin
			fold_word({held, b});
			odd_pend = 1'b0;
			held = '0;
		end else begin
			held = b;
			odd_pend = 1'b1;
		end
	endfunction

	function automatic void close_sum();
		logic [SUM_W-1:0] c;
		if (odd_pend)
			fold_word({held, 8'h00});
		c = ~csum;
		exp_beats.push_back('{out_byte: c[7:0], last: 1'b0});
		exp_beats.push_back('{out_byte: c[15:8], last: 1'b1});
		pk_open = 1'b0;
		pk_left = '0;
		csum = '0;
		held = '0;
		odd_pend = 1'b0;
		n_packets++;
	endfunction

	function automatic void frame_item(input logic cmd, input logic knd,
			input logic [TYPE_W-1:0] mt, input logic [LEN_W-1:0] pl,
			input logic [BYTE_W-1:0] db);
		logic [PORT_W-1:0] dst;
		logic [LEN_W-1:0]  carried;
		logic [3:0]        ty;
		logic [15:0]       lt;
		if (cmd == CMD_START) begin
			dst = (knd == KIND_MESSAGE) ? MSG_DST_PORT : CTRL_DST_PORT;
			carried = (knd == KIND_MESSAGE) ? pl + MSG_SUBHDR_LEN : pl;
			ty = (knd == KIND_MESSAGE) ? MSG_TYPE : CTRL_TYPE;
			lt = {ty, carried};
			csum = '0;
			held = '0;
			odd_pend = 1'b0;
			emit_byte(HDR_VERSION);
			emit_byte(src_port_q[7:0]);
			emit_byte(src_port_q[15:8]);
			emit_byte(dst[7:0]);
			emit_byte(dst[15:8]);
			emit_byte(lt[7:0]);
			emit_byte(lt[15:8]);
			if (carried[0])
				emit_byte(8'h00);
			if (knd == KIND_MESSAGE) begin
				emit_byte(sess_id_q[7:0]);
				emit_byte({mt[5:4], sess_id_q[13:8]});
				emit_byte({mt[3:0], pl[11:8]});
				emit_byte(pl[7:0]);
			end
			pk_open = 1'b1;
			pk_left = pl;
			if (pl == '0)
				close_sum();
		end else if (pk_open) begin
			emit_byte(db);
			pk_left = pk_left - 1'b1;
			if (pk_left == '0)
				close_sum();
		end else begin
			n_strays++;
		end
	endfunction

	task automatic send_item(input logic cmd, input logic knd, input logic [TYPE_W-1:0] mt,
			input logic [LEN_W-1:0] pl, input logic [BYTE_W-1:0] db);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.command        <= cmd;
		item_ch.packet_kind    <= knd;
		item_ch.message_type   <= mt;
		item_ch.payload_length <= pl;
		item_ch.data_byte      <= db;
		do @(posedge clk); while (!item_ch.ready);
		frame_item(cmd, knd, mt, pl, db);
		n_items++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] db);
		send_item(CMD_PAYLOAD, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
			12'($urandom_range(0, 4095)), db);
	endtask

	task automatic send_bytes(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic start_packet(input logic knd, input logic [TYPE_W-1:0] mt,
			input logic [LEN_W-1:0] pl);
		send_item(CMD_START, knd, mt, pl, 8'($urandom_range(0, 255)));
	endtask

	task automatic run_packet(input logic knd, input logic [TYPE_W-1:0] mt,
			input logic [LEN_W-1:0] pl);
		start_packet(knd, mt, pl);
		send_bytes(int'(pl));
	endtask

	// close any open packet, then wait for the block to go quiet
	task automatic settle();
		int guard;
		if (pk_open)
			send_bytes(int'(pk_left));
		item_ch.valid <= 1'b0;
		guard = 0;
		while (exp_beats.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (exp_beats.size() != 0) begin
			$error("%0d expected beats never arrived", exp_beats.size());
			fails++;
			exp_beats.delete();
		end
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SOURCE_PORT)
			src_port_q = v[PORT_W-1:0];
		else
			sess_id_q = v[SID_W-1:0];
	endtask

	task automatic apply_cfg(input logic [PDATA_W-1:0] sp, input logic [PDATA_W-1:0] sid);
		settle();
		cfg_write(REG_SOURCE_PORT, sp);
		cfg_write(REG_SESSION_ID, sid);
		n_settings++;
	endtask

	task automatic test_reset_values();
		run_packet(KIND_CONTROL, 6'($urandom_range(0, 63)), 12'd0);
		run_packet(KIND_MESSAGE, 6'h3F, 12'd0);
		run_packet(KIND_CONTROL, 6'($urandom_range(0, 63)), 12'd1);
		run_packet(KIND_MESSAGE, 6'h00, 12'd2);
	endtask

	task automatic test_byte_extremes();
		start_packet(KIND_CONTROL, 6'h15, 12'd3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		start_packet(KIND_MESSAGE, 6'h2A, 12'd2);
		send_byte(8'hFF);
		send_byte(8'hFF);
	endtask

	task automatic test_stray_bytes();
		send_byte(8'h5A);
		send_byte(8'hA5);
		run_packet(KIND_CONTROL, 6'h00, 12'd0);
	endtask

	task automatic test_restart_and_wrap();
		start_packet(KIND_CONTROL, 6'h3F, 12'd5);
		send_bytes(2);
		start_packet(KIND_MESSAGE, 6'h11, 12'd3);
		send_bytes(3);
		// carried length 4 + 4095 wraps to 3, odd: pad follows
		start_packet(KIND_MESSAGE, 6'h3F, 12'hFFF);
		send_bytes(1);
		start_packet(KIND_CONTROL, 6'h3F, 12'hFFF);
		start_packet(KIND_MESSAGE, 6'h30, 12'hFFC);
		start_packet(KIND_CONTROL, 6'h00, 12'd0);
	endtask

	task automatic test_config_extremes();
		apply_cfg(32'h0000_0000, 32'h0000_0000);
		run_packet(KIND_CONTROL, 6'h3F, 12'd1);
		run_packet(KIND_MESSAGE, 6'h3F, 12'd1);
		apply_cfg(32'h0000_FFFF, 32'h0000_3FFF);
		run_packet(KIND_CONTROL, 6'h00, 12'd2);
		run_packet(KIND_MESSAGE, 6'h3F, 12'd3);
		apply_cfg(32'hA5A5_0001, 32'hFFFF_C000);
		run_packet(KIND_MESSAGE, 6'h0F, 12'd0);
	endtask

	task automatic random_chunk(input int target);
		int base;
		int r;
		int pl;
		int k;
		base = n_items - n_strays;
		while (n_items - n_strays - base < target) begin
			r = $urandom_range(0, 99);
			if (r < 8 && !pk_open) begin
				send_bytes($urandom_range(1, 3));
			end else if (r < 16) begin
				// abandoned packet, any length (a zero length closes with its checksum)
				pl = $urandom_range(0, 4095);
				start_packet(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), 12'(pl));
				if (pl > 1) begin
					k = $urandom_range(0, (pl - 1 < 3) ? pl - 1 : 3);
					send_bytes(k);
				end
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75)
					pl = $urandom_range(0, 8);
				else if (r < 95)
					pl = $urandom_range(9, 40);
				else
					pl = $urandom_range(41, 120);
				run_packet(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), 12'(pl));
			end
		end
		run_packet(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
			12'($urandom_range(0, 6)));
	endtask

	task automatic test_random_traffic();
		for (int c = 0; c < 4; c++) begin
			apply_cfg($urandom, $urandom);
			random_chunk(50);
		end
	endtask

	// output backpressure
	initial begin
		int stall;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 99) < 25) begin
				result_ch.ready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		quiet <= 1'b0;
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			quiet <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		beat_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			n_beats++;
			if (exp_beats.size() == 0) begin
				$error("unexpected beat: out_byte %02h last %0b", result_ch.out_byte,
					result_ch.last);
				fails++;
			end else begin
				e = exp_beats.pop_front();
				if (result_ch.out_byte !== e.out_byte) begin
					$error("out_byte mismatch: expected %02h actual %02h", e.out_byte,
						result_ch.out_byte);
					fails++;
				end
				if (result_ch.last !== e.last) begin
					$error("last mismatch: expected %0b actual %0b", e.last, result_ch.last);
					fails++;
				end
			end
		end
	end

	initial begin
		fails      = 0;
		n_items    = 0;
		n_strays   = 0;
		n_beats    = 0;
		n_packets  = 0;
		n_settings = 0;
		src_port_q = SOURCE_PORT_RST;
		sess_id_q  = SESSION_ID_RST;
		pk_open    = 1'b0;
		pk_left    = '0;
		csum       = '0;
		held       = '0;
		odd_pend   = 1'b0;

		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		item_ch.valid          <= 1'b0;
		item_ch.command        <= CMD_START;
		item_ch.packet_kind    <= KIND_CONTROL;
		item_ch.message_type   <= '0;
		item_ch.payload_length <= '0;
		item_ch.data_byte      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_byte_extremes();
		test_stray_bytes();
		test_restart_and_wrap();
		test_config_extremes();
		test_random_traffic();
		settle();

		$display("tb: %0d items in (%0d stray), %0d beats checked, %0d packets closed",
			n_items, n_strays, n_beats, n_packets);
		$display("tb: %0d register settings incl. extremes, abandoned and wrapped lengths",
			n_settings);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
